[rtl/core/ltrc_pkg.sv]
// Package for the left-to-right character calculator.
// Holds payload structs, operator codes, character constants and the ALU command struct.
// Depends on nothing.
package ltrc_pkg;

  localparam int VALUE_WIDTH = 64;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } ltrc_in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } ltrc_out_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } ltrc_op_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_CHAR  = 2'd2;

  // Command to the shared arithmetic unit.
  typedef struct packed {
    logic                   start;
    ltrc_op_t               op;
    logic [VALUE_WIDTH-1:0] a;
    logic [VALUE_WIDTH-1:0] b;
  } ltrc_alu_cmd_t;

  // Response from the shared arithmetic unit.
  typedef struct packed {
    logic                   done;
    logic                   div_zero;
    logic [VALUE_WIDTH-1:0] y;
  } ltrc_alu_rsp_t;

  function automatic ltrc_op_t op_of(input logic [7:0] c);
    case (c)
      CH_PLUS:  op_of = OP_ADD;
      CH_MINUS: op_of = OP_SUB;
      CH_STAR:  op_of = OP_MUL;
      CH_SLASH: op_of = OP_DIV;
      CH_PCT:   op_of = OP_MOD;
      default:  op_of = OP_NONE;
    endcase
  endfunction

endpackage

[rtl/core/ltrc_alu.sv]
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide and modulo.
// Multiply and divide retire one bit per cycle. Depends on ltrc_pkg.
module ltrc_alu
  import ltrc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ltrc_alu_cmd_t cmd,
  output ltrc_alu_rsp_t rsp
);

  localparam int W = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIX} state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [W-1:0]   acc;
  logic [W-1:0]   mcand;
  logic [W-1:0]   quo;
  logic [W-1:0]   rem;
  logic [W-1:0]   dvsr;
  logic           neg_a;
  logic           neg_b;
  ltrc_op_t       op;

  logic [W:0]     trial;
  logic [W-1:0]   abs_a;
  logic [W-1:0]   abs_b;
  logic           done_next;

  assign abs_a = cmd.a[W-1] ? (~cmd.a + 1'b1) : cmd.a;
  assign abs_b = cmd.b[W-1] ? (~cmd.b + 1'b1) : cmd.b;
  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quo[W-1]} - {1'b0, dvsr};

  // Done is raised for commands other than multiply, divide and modulo, a zero divisor, and the final fix-up step.
  assign done_next = !rst && ((state == S_FIX) ||
                     ((state == S_IDLE) && cmd.start && (cmd.op != OP_MUL) &&
                      !(((cmd.op == OP_DIV) || (cmd.op == OP_MOD)) && (cmd.b != '0))));

  // Sequencer and datapath of the shared unit.
  always_ff @(posedge clk) begin
    rsp.done <= done_next;
    if (rst) begin
      state <= S_IDLE;
      rsp.div_zero <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            op <= cmd.op;
            rsp.div_zero <= 1'b0;
            count <= '0;
            case (cmd.op)
              OP_ADD: begin
                rsp.y <= cmd.a + cmd.b;
              end
              OP_SUB: begin
                rsp.y <= cmd.a - cmd.b;
              end
              OP_MUL: begin
                acc <= '0;
                mcand <= cmd.a;
                quo <= cmd.b;
                state <= S_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (cmd.b == '0) begin
                  rsp.y <= '0;
                  rsp.div_zero <= 1'b1;
                end else begin
                  neg_a <= cmd.a[W-1];
                  neg_b <= cmd.b[W-1];
                  quo <= abs_a;
                  rem <= '0;
                  dvsr <= abs_b;
                  state <= S_DIV;
                end
              end
              default: begin
                rsp.y <= cmd.a;
              end
            endcase
          end
        end
        S_MUL: begin
          if (quo[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          quo <= quo >> 1;
          count <= count + 1'b1;
          if (count == CW'(W - 1)) state <= S_FIX;
        end
        S_DIV: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= {rem[W-2:0], quo[W-1]};
            quo <= {quo[W-2:0], 1'b0};
          end
          count <= count + 1'b1;
          if (count == CW'(W - 1)) state <= S_FIX;
        end
        S_FIX: begin
          // Apply signs and deliver the result.
          if (op == OP_MUL) rsp.y <= acc;
          else if (op == OP_DIV) rsp.y <= (neg_a != neg_b) ? (~quo + 1'b1) : quo;
          else rsp.y <= neg_a ? (~rem + 1'b1) : rem;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/left_to_right_char_calculator_unit.sv]
// Top level of the left-to-right character calculator: parser sequencer and output register.
// Depends on ltrc_pkg and ltrc_alu.
//
//   channel | valid     | ready     | payload
//   input   | in_valid  | in_ready  | in_data  (ltrc_in_t)
//   output  | out_valid | out_ready | out_data (ltrc_out_t)
//
// A space, a stray character or an operator that applies nothing needs no arithmetic.
// A digit runs times ten through the shift-add multiplier, then adds the digit.
// An operator that applies multiply, divide or modulo waits for the iterative unit, and a
// digit that ends the line after such an operator runs both of these steps in turn.
// Reset is synchronous and clears the parser state and out_valid. A result waits in the output
// register; the block stalls only when a new result is due while it is still full.
module left_to_right_char_calculator_unit
  import ltrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ltrc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ltrc_out_t out_data
);

  localparam int W = VALUE_WIDTH;

  typedef enum logic [2:0] {S_IDLE, S_DIGIT, S_APPLY, S_EMIT, S_WAIT} state_t;

  state_t         state;
  logic [W-1:0]   left_operand;
  logic [W-1:0]   right_operand;
  logic           right_digits_seen;
  ltrc_op_t       held_operator;
  logic           first_operand_done;
  logic           computed_once;
  logic [W-1:0]   running_result;
  logic [1:0]     status_flags;
  logic           last;
  logic           digit_right;
  logic           after_apply;
  logic [3:0]     digit;
  ltrc_op_t       new_op;
  ltrc_alu_cmd_t  cmd;
  ltrc_alu_rsp_t  rsp;

  logic           is_space;
  logic           is_digit;
  logic           held;
  ltrc_op_t       in_op;
  state_t         char_state;
  logic           start_next;

  ltrc_alu u_alu (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  // Character classification of the incoming request.
  assign in_op    = op_of(in_data.character);
  assign is_space = (in_data.character == CH_SPACE) ||
                    ((in_data.character >= CH_TAB) && (in_data.character <= CH_CR));
  assign is_digit = (in_data.character >= CH_ZERO) && (in_data.character <= CH_NINE);
  assign held     = (held_operator != OP_NONE);
  assign in_ready = (state == S_IDLE);

  // State after a character that needs no arithmetic.
  assign char_state = in_data.line_end ? S_APPLY : S_IDLE;

  // The shared unit starts on a digit that extends an operand or on a pending operation.
  assign start_next = !rst &&
    (((state == S_IDLE) && in_valid && is_digit && (!first_operand_done || held)) ||
     ((state == S_APPLY) && !after_apply && held && right_digits_seen));

  // Main sequencer: parses one character, then drives the shared unit as needed.
  always_ff @(posedge clk) begin
    cmd.start <= start_next;
    if (rst) begin
      state <= S_IDLE;
      left_operand <= '0;
      right_operand <= '0;
      right_digits_seen <= 1'b0;
      held_operator <= OP_NONE;
      first_operand_done <= 1'b0;
      computed_once <= 1'b0;
      running_result <= '0;
      status_flags <= 2'b00;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last <= in_data.line_end;
            after_apply <= 1'b0;
            if (is_space) begin
              state <= char_state;
            end else if (is_digit) begin
              digit <= 4'(in_data.character - CH_ZERO);
              if (!first_operand_done || held) begin
                // Times ten in the shared unit, then add the digit.
                digit_right <= first_operand_done;
                cmd.op <= OP_MUL;
                cmd.a <= first_operand_done ? right_operand : left_operand;
                cmd.b <= W'(10);
                state <= S_DIGIT;
              end else begin
                status_flags[1] <= 1'b1;
                state <= char_state;
              end
            end else if (in_op != OP_NONE) begin
              first_operand_done <= 1'b1;
              new_op <= in_op;
              if (held && right_digits_seen) begin
                state <= S_APPLY;
              end else begin
                held_operator <= in_op;
                state <= char_state;
              end
            end else begin
              status_flags[1] <= 1'b1;
              state <= char_state;
            end
          end
        end
        S_DIGIT: begin
          if (rsp.done) begin
            if (digit_right) begin
              right_operand <= rsp.y + W'(digit);
              right_digits_seen <= 1'b1;
            end else begin
              left_operand <= rsp.y + W'(digit);
            end
            state <= last ? S_APPLY : S_IDLE;
          end
        end
        S_APPLY: begin
          // Apply the pending operation if there is one.
          if (!after_apply) begin
            if (held && right_digits_seen) begin
              cmd.op <= held_operator;
              cmd.a <= computed_once ? running_result : left_operand;
              cmd.b <= right_operand;
              after_apply <= 1'b1;
            end else begin
              state <= last ? S_EMIT : S_IDLE;
            end
          end else if (rsp.done) begin
            running_result <= rsp.y;
            computed_once <= 1'b1;
            right_operand <= '0;
            right_digits_seen <= 1'b0;
            if (rsp.div_zero) status_flags[0] <= 1'b1;
            after_apply <= 1'b0;
            // An operator that triggered the step becomes the new held one, unless the line ends here.
            held_operator <= last ? OP_NONE : new_op;
            state <= last ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.result_value <= 64'($signed(running_result));
            out_data.status <= status_flags[1] ? ST_CHAR :
                               (status_flags[0] ? ST_DIVZ : ST_OK);
            left_operand <= '0;
            right_operand <= '0;
            right_digits_seen <= 1'b0;
            held_operator <= OP_NONE;
            first_operand_done <= 1'b0;
            computed_once <= 1'b0;
            running_result <= '0;
            status_flags <= 2'b00;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only raised from the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit step");

  // No request is taken while the shared unit runs a digit update.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> !in_ready)
    else $error("request accepted during digit update");

  // A held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule
